// File: hdl/dmsc_pkg.sv
// Package: types, codes and timer helpers for the dead-man switch controller.
`timescale 1ns / 1ps

package dmsc_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
   localparam int REQ_BITS    = 16;
   localparam int RSP_BITS    = 8;
   localparam int CSR_IDX_BITS = 3;

   typedef logic [TIMER_WIDTH-1:0] timer_type;
   typedef logic [CFG_WIDTH-1:0]   cfg_word_type;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_ARMING   = 2'd1,
      MODE_CRUISING = 2'd2,
      MODE_MENU     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      GS_WAITING = 2'd0,
      GS_FIRST   = 2'd1,
      GS_BOTH    = 2'd2
   } gesture_type;

   typedef enum logic [2:0] {
      MSG_NONE      = 3'd0,
      MSG_START     = 3'd1,
      MSG_STOP      = 3'd2,
      MSG_KEEPALIVE = 3'd3,
      MSG_VALUE     = 3'd4
   } message_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_STOP_DELAY  = 3'd0,
      REG_ARMING      = 3'd1,
      REG_KEEPALIVE   = 3'd2,
      REG_DUAL_WINDOW = 3'd3,
      REG_DUAL_HOLD   = 3'd4,
      REG_MENU_TIMEOUT = 3'd5,
      REG_TAP_WINDOW  = 3'd6
   } reg_index_type;

   typedef struct packed {
      cfg_word_type stop_delay_ms;
      cfg_word_type arming_ms;
      cfg_word_type keepalive_ms;
      cfg_word_type dual_window_ms;
      cfg_word_type dual_hold_ms;
      cfg_word_type menu_idle_limit_ms;
      cfg_word_type tap_window_ms;
   } cfg_type;

   // Packed from the top down, so up_held lands in bit 0.
   typedef struct packed {
      logic [7:0] elapsed_ms;
      logic       link_stop;
      logic       down_press_event;
      logic       up_press_event;
      logic       down_held;
      logic       up_held;
   } req_type;

   typedef struct packed {
      logic        delay_active;
      message_type message;
      mode_type    ctl_mode;
   } rsp_type;

   function automatic timer_type sat_add(input timer_type t, input logic [7:0] dt);
      logic [TIMER_WIDTH:0] s;
      s = {1'b0, t} + {{(TIMER_WIDTH - 7){1'b0}}, dt};
      return s[TIMER_WIDTH] ? {TIMER_WIDTH{1'b1}} : s[TIMER_WIDTH-1:0];
   endfunction

   function automatic logic timer_ge(input timer_type t, input cfg_word_type thr);
      logic [CMP_WIDTH-1:0] a;
      logic [CMP_WIDTH-1:0] b;
      a = CMP_WIDTH'(t);
      b = CMP_WIDTH'(thr);
      return a >= b;
   endfunction

   function automatic logic timer_gt(input timer_type t, input cfg_word_type thr);
      logic [CMP_WIDTH-1:0] a;
      logic [CMP_WIDTH-1:0] b;
      a = CMP_WIDTH'(t);
      b = CMP_WIDTH'(thr);
      return a > b;
   endfunction

endpackage

// File: hdl/dmsc_csr.sv
// Configuration register file for the dead-man switch controller.
`timescale 1ns / 1ps

module dmsc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [dmsc_pkg::CSR_IDX_BITS-1:0]   wr_index,
   input  dmsc_pkg::cfg_word_type              wr_data,
   output dmsc_pkg::cfg_type                   cfg
);
   import dmsc_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_delay_ms      <= 16'd3000;
         cfg_ff.arming_ms          <= 16'd1000;
         cfg_ff.keepalive_ms       <= 16'd500;
         cfg_ff.dual_window_ms     <= 16'd150;
         cfg_ff.dual_hold_ms       <= 16'd600;
         cfg_ff.menu_idle_limit_ms <= 16'd1500;
         cfg_ff.tap_window_ms      <= 16'd1500;
      end else if (wr_en) begin
         case (wr_index)
            REG_STOP_DELAY:   cfg_ff.stop_delay_ms      <= wr_data;
            REG_ARMING:       cfg_ff.arming_ms          <= wr_data;
            REG_KEEPALIVE:    cfg_ff.keepalive_ms       <= wr_data;
            REG_DUAL_WINDOW:  cfg_ff.dual_window_ms     <= wr_data;
            REG_DUAL_HOLD:    cfg_ff.dual_hold_ms       <= wr_data;
            REG_MENU_TIMEOUT: cfg_ff.menu_idle_limit_ms <= wr_data;
            REG_TAP_WINDOW:   cfg_ff.tap_window_ms      <= wr_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/dmsc_core.sv
// Controller state, timers and the per-pass update logic.
`timescale 1ns / 1ps

module dmsc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  dmsc_pkg::req_type req,
   input  dmsc_pkg::cfg_type cfg,
   output dmsc_pkg::rsp_type rsp
);
   import dmsc_pkg::*;

   mode_type    mode_ff, mode_in;
   gesture_type gs_ff, gs_in;
   logic [1:0]  tap_ff, tap_in;
   logic        gdone_ff, gdone_in;
   logic        rrun_ff, rrun_in;
   logic        dflag_ff, dflag_in;
   timer_type   fp_ff, fp_in;
   timer_type   bh_ff, bh_in;
   timer_type   ar_ff, ar_in;
   timer_type   ka_ff, ka_in;
   timer_type   rl_ff, rl_in;
   timer_type   mi_ff, mi_in;
   timer_type   tg_ff, tg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         gs_ff    <= GS_WAITING;
         tap_ff   <= 2'd0;
         gdone_ff <= 1'b0;
         rrun_ff  <= 1'b0;
         dflag_ff <= 1'b0;
         fp_ff    <= '0;
         bh_ff    <= '0;
         ar_ff    <= '0;
         ka_ff    <= '0;
         rl_ff    <= '0;
         mi_ff    <= '0;
         tg_ff    <= '1;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         gs_ff    <= gs_in;
         tap_ff   <= tap_in;
         gdone_ff <= gdone_in;
         rrun_ff  <= rrun_in;
         dflag_ff <= dflag_in;
         fp_ff    <= fp_in;
         bh_ff    <= bh_in;
         ar_ff    <= ar_in;
         ka_ff    <= ka_in;
         rl_ff    <= rl_in;
         mi_ff    <= mi_in;
         tg_ff    <= tg_in;
      end
   end

   always_comb begin
      logic        any_held;
      logic        both_held;
      logic [1:0]  ev;
      message_type msg;
      any_held  = req.up_held | req.down_held;
      both_held = req.up_held & req.down_held;
      ev        = {req.down_press_event, req.up_press_event};
      msg       = MSG_NONE;

      mode_in  = mode_ff;
      gs_in    = gs_ff;
      tap_in   = tap_ff;
      gdone_in = gdone_ff;
      rrun_in  = rrun_ff;
      dflag_in = dflag_ff;
      fp_in    = sat_add(fp_ff, req.elapsed_ms);
      bh_in    = sat_add(bh_ff, req.elapsed_ms);
      ar_in    = sat_add(ar_ff, req.elapsed_ms);
      ka_in    = sat_add(ka_ff, req.elapsed_ms);
      rl_in    = sat_add(rl_ff, req.elapsed_ms);
      mi_in    = sat_add(mi_ff, req.elapsed_ms);
      tg_in    = sat_add(tg_ff, req.elapsed_ms);

      if (req.link_stop) begin
         mode_in  = MODE_IDLE;
         dflag_in = 1'b0;
      end

      // Up press is handled first; a down press in the same pass sees a zero gap.
      for (int i = 0; i < 2; i++) begin
         if (ev[i] && mode_in == MODE_IDLE) begin
            if (timer_gt(tg_in, cfg.tap_window_ms)) begin
               tap_in = 2'd0;
            end
            tap_in = tap_in + 2'd1;
            tg_in  = '0;
            if (tap_in == 2'd3) begin
               mode_in = MODE_MENU;
               mi_in   = '0;
               tap_in  = 2'd0;
            end
         end
      end

      case (mode_in)
         MODE_IDLE: begin
            case (gs_in)
               GS_FIRST: begin
                  if (both_held) begin
                     gs_in    = GS_BOTH;
                     bh_in    = '0;
                     gdone_in = 1'b0;
                  end else if (timer_gt(fp_in, cfg.dual_window_ms)) begin
                     gs_in   = GS_WAITING;
                     mode_in = MODE_ARMING;
                     ar_in   = '0;
                  end else if (!any_held) begin
                     gs_in = GS_WAITING;
                  end
               end
               GS_BOTH: begin
                  if (!both_held) begin
                     gs_in = GS_WAITING;
                  end else if (!gdone_in && timer_ge(bh_in, cfg.dual_hold_ms)) begin
                     dflag_in = ~dflag_in;
                     gdone_in = 1'b1;
                  end
               end
               default: begin
                  gs_in = GS_WAITING;
                  if (any_held) begin
                     gs_in = GS_FIRST;
                     fp_in = '0;
                  end
               end
            endcase
         end
         MODE_ARMING: begin
            if (!any_held) begin
               mode_in = MODE_IDLE;
            end else if (timer_ge(ar_in, cfg.arming_ms)) begin
               msg     = MSG_START;
               mode_in = MODE_CRUISING;
               ka_in   = '0;
               rrun_in = 1'b0;
            end
         end
         MODE_CRUISING: begin
            if (any_held) begin
               rrun_in = 1'b0;
               if (timer_ge(ka_in, cfg.keepalive_ms)) begin
                  msg   = MSG_KEEPALIVE;
                  ka_in = '0;
               end
            end else if (dflag_in) begin
               if (!rrun_in) begin
                  rrun_in = 1'b1;
                  rl_in   = '0;
               end else if (timer_ge(rl_in, cfg.stop_delay_ms)) begin
                  msg      = MSG_STOP;
                  mode_in  = MODE_IDLE;
                  dflag_in = 1'b0;
               end
            end else begin
               msg     = MSG_STOP;
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            if (any_held) begin
               mi_in = '0;
            end
            if (timer_gt(mi_in, cfg.menu_idle_limit_ms)) begin
               msg     = MSG_VALUE;
               mode_in = MODE_IDLE;
            end
         end
      endcase

      rsp.ctl_mode     = mode_in;
      rsp.message      = msg;
      rsp.delay_active = dflag_in;
   end

endmodule

// File: hdl/dead_man_switch_controller.sv
// Top level of the dead-man switch controller: stream ports, input and result registers.
//
//   channel   direction  handshake                 payload
//   req_      in         req_tvalid / req_tready   req_tdata  (16 bits)
//   rsp_      out        rsp_tvalid / rsp_tready   rsp_tdata  (8 bits)
//   csr_      in         csr_valid / csr_ready     csr_index, csr_data
//
// One control pass a cycle unless the output stalls: a beat sits in the input
// register, the update logic between it and the result register is combinational,
// and the state advances as the result is loaded, once the result register is free.
// Reset is synchronous and restores the register defaults and the idle state.
// A waiting result does not block the input: one more beat is taken into the
// input register, and only then does the input stall until the result is taken.
`timescale 1ns / 1ps

module dead_man_switch_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // up_held, down_held, up_press_event, down_press_event, link_stop,
   // elapsed_ms[7:0], zero fill
   input  logic [dmsc_pkg::REQ_BITS-1:0]        req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // ctl_mode[1:0], message[2:0], delay_active, zero fill
   output logic [dmsc_pkg::RSP_BITS-1:0]        rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dmsc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  dmsc_pkg::cfg_word_type               csr_data
);
   import dmsc_pkg::*;

   localparam int REQ_USED = $bits(req_type);
   localparam int RSP_USED = $bits(rsp_type);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   rsp_type step_rsp;
   cfg_type cfg;
   logic    step_en;
   logic    req_fire;

   assign step_en    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | step_en;
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (step_en) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_tdata[REQ_USED-1:0];
      end
      if (step_en) begin
         out_data_ff <= step_rsp;
      end
   end

   dmsc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   dmsc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_BITS - RSP_USED){1'b0}}, out_data_ff};

endmodule

// File: tb/dmsc_pass_checker.sv
// Checker for the dead-man switch controller: predicts each control pass and compares results.
`timescale 1ns / 1ps

module dmsc_pass_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [dmsc_pkg::REQ_BITS-1:0]       req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [dmsc_pkg::RSP_BITS-1:0]       rsp_tdata,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [dmsc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  dmsc_pkg::cfg_word_type              csr_data,
   output int                                  fail_count,
   output int                                  pending
);
   import dmsc_pkg::*;

   cfg_type     cfg;
   mode_type    mode;
   gesture_type gest;
   logic [1:0]  taps;
   logic        gest_done;
   logic        release_on;
   logic        delay_on;
   timer_type   t_first;
   timer_type   t_both;
   timer_type   t_arm;
   timer_type   t_keep;
   timer_type   t_release;
   timer_type   t_menu;
   timer_type   t_gap;

   rsp_type     expected_reports[$];
   rsp_type     seen_report;
   rsp_type     due_report;
   rsp_type     next_report;
   int          errors = 0;

   function automatic timer_type bump(input timer_type t, input logic [7:0] dt);
      logic [TIMER_WIDTH:0] sum;
      sum = {1'b0, t} + (TIMER_WIDTH + 1)'(dt);
      if (sum > (TIMER_WIDTH + 1)'({TIMER_WIDTH{1'b1}})) begin
         return {TIMER_WIDTH{1'b1}};
      end
      return sum[TIMER_WIDTH-1:0];
   endfunction

   task automatic restore_defaults();
      cfg.stop_delay_ms      = 16'd3000;
      cfg.arming_ms          = 16'd1000;
      cfg.keepalive_ms       = 16'd500;
      cfg.dual_window_ms     = 16'd150;
      cfg.dual_hold_ms       = 16'd600;
      cfg.menu_idle_limit_ms = 16'd1500;
      cfg.tap_window_ms      = 16'd1500;
      mode       = MODE_IDLE;
      gest       = GS_WAITING;
      taps       = '0;
      gest_done  = 1'b0;
      release_on = 1'b0;
      delay_on   = 1'b0;
      t_first    = '0;
      t_both     = '0;
      t_arm      = '0;
      t_keep     = '0;
      t_release  = '0;
      t_menu     = '0;
      t_gap      = '1;
   endtask

   task automatic write_register(input logic [CSR_IDX_BITS-1:0] idx, input cfg_word_type val);
      case (idx)
         REG_STOP_DELAY:   cfg.stop_delay_ms      = val;
         REG_ARMING:       cfg.arming_ms          = val;
         REG_KEEPALIVE:    cfg.keepalive_ms       = val;
         REG_DUAL_WINDOW:  cfg.dual_window_ms     = val;
         REG_DUAL_HOLD:    cfg.dual_hold_ms       = val;
         REG_MENU_TIMEOUT: cfg.menu_idle_limit_ms = val;
         REG_TAP_WINDOW:   cfg.tap_window_ms      = val;
         default: begin
         end
      endcase
   endtask

   // Taps only count in idle; the third one within the window opens the menu.
   task automatic count_tap();
      if (mode == MODE_IDLE) begin
         if (t_gap > cfg.tap_window_ms) begin
            taps = '0;
         end
         taps  = taps + 2'd1;
         t_gap = '0;
         if (taps == 2'd3) begin
            mode   = MODE_MENU;
            t_menu = '0;
            taps   = '0;
         end
      end
   endtask

   task automatic run_control_pass(input req_type r, output rsp_type o);
      logic        any_held;
      logic        both_held;
      message_type note;
      any_held  = r.up_held | r.down_held;
      both_held = r.up_held & r.down_held;
      note      = MSG_NONE;

      t_first   = bump(t_first, r.elapsed_ms);
      t_both    = bump(t_both, r.elapsed_ms);
      t_arm     = bump(t_arm, r.elapsed_ms);
      t_keep    = bump(t_keep, r.elapsed_ms);
      t_release = bump(t_release, r.elapsed_ms);
      t_menu    = bump(t_menu, r.elapsed_ms);
      t_gap     = bump(t_gap, r.elapsed_ms);

      if (r.link_stop) begin
         mode     = MODE_IDLE;
         delay_on = 1'b0;
      end
      if (r.up_press_event) begin
         count_tap();
      end
      if (r.down_press_event) begin
         count_tap();
      end

      case (mode)
         MODE_IDLE: begin
            if (gest == GS_FIRST) begin
               if (both_held) begin
                  gest      = GS_BOTH;
                  t_both    = '0;
                  gest_done = 1'b0;
               end else if (t_first > cfg.dual_window_ms) begin
                  gest  = GS_WAITING;
                  mode  = MODE_ARMING;
                  t_arm = '0;
               end else if (!any_held) begin
                  gest = GS_WAITING;
               end
            end else if (gest == GS_BOTH) begin
               if (!both_held) begin
                  gest = GS_WAITING;
               end else if (!gest_done && t_both >= cfg.dual_hold_ms) begin
                  delay_on  = !delay_on;
                  gest_done = 1'b1;
               end
            end else begin
               gest = GS_WAITING;
               if (any_held) begin
                  gest    = GS_FIRST;
                  t_first = '0;
               end
            end
         end
         MODE_ARMING: begin
            if (!any_held) begin
               mode = MODE_IDLE;
            end else if (t_arm >= cfg.arming_ms) begin
               note       = MSG_START;
               mode       = MODE_CRUISING;
               t_keep     = '0;
               release_on = 1'b0;
            end
         end
         MODE_CRUISING: begin
            if (any_held) begin
               release_on = 1'b0;
               if (t_keep >= cfg.keepalive_ms) begin
                  note   = MSG_KEEPALIVE;
                  t_keep = '0;
               end
            end else if (delay_on) begin
               if (!release_on) begin
                  release_on = 1'b1;
                  t_release  = '0;
               end else if (t_release >= cfg.stop_delay_ms) begin
                  note     = MSG_STOP;
                  mode     = MODE_IDLE;
                  delay_on = 1'b0;
               end
            end else begin
               note = MSG_STOP;
               mode = MODE_IDLE;
            end
         end
         default: begin
            if (any_held) begin
               t_menu = '0;
            end
            if (t_menu > cfg.menu_idle_limit_ms) begin
               note = MSG_VALUE;
               mode = MODE_IDLE;
            end
         end
      endcase

      o.ctl_mode     = mode;
      o.message      = note;
      o.delay_active = delay_on;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
         expected_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            write_register(csr_index, csr_data);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_report = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (expected_reports.size() == 0) begin
               errors++;
               $display("%0t: result beat %h arrived with nothing expected", $time, rsp_tdata);
            end else begin
               due_report = expected_reports.pop_front();
               if (seen_report.ctl_mode !== due_report.ctl_mode) begin
                  errors++;
                  $display("%0t: ctl_mode expected %0d, got %0d", $time,
                           due_report.ctl_mode, seen_report.ctl_mode);
               end
               if (seen_report.message !== due_report.message) begin
                  errors++;
                  $display("%0t: message expected %0d, got %0d", $time,
                           due_report.message, seen_report.message);
               end
               if (seen_report.delay_active !== due_report.delay_active) begin
                  errors++;
                  $display("%0t: delay_active expected %0d, got %0d", $time,
                           due_report.delay_active, seen_report.delay_active);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            run_control_pass(req_type'(req_tdata[$bits(req_type)-1:0]), next_report);
            expected_reports.push_back(next_report);
         end
      end
      pending    <= expected_reports.size();
      fail_count <= errors;
   end

endmodule

// File: tb/tb_dead_man_switch_controller.sv
// Testbench top for the dead-man switch controller: stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module tb_dead_man_switch_controller;
   import dmsc_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int PHASES = 8;
   localparam int PASSES_PER_PHASE = 140;
   localparam logic [CSR_IDX_BITS-1:0] UNUSED_REG = 3'd7;

   typedef enum {
      CFG_RESET, CFG_SMALL, CFG_ZERO, CFG_TOP, CFG_ONES, CFG_DEFAULT, CFG_WIDE
   } cfg_plan_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]       rsp_tdata;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index = '0;
   cfg_word_type              csr_data = '0;

   int fail_count;
   int pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int passes_sent = 0;
   int quiet_cycles = 0;

   dead_man_switch_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   dmsc_pass_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_dead_man_switch_controller: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type build_pass(input logic up, input logic dn, input logic up_ev,
                                          input logic dn_ev, input logic stop,
                                          input logic [7:0] dt);
      req_type r;
      r.up_held          = up;
      r.down_held        = dn;
      r.up_press_event   = up_ev;
      r.down_press_event = dn_ev;
      r.link_stop        = stop;
      r.elapsed_ms       = dt;
      return r;
   endfunction

   function automatic logic [7:0] pick_dt();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(1, 254));
      endcase
   endfunction

   function automatic logic rare_stop();
      return $urandom_range(39) == 0;
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   function automatic cfg_type make_cfg(input cfg_plan_type plan);
      cfg_type c;
      case (plan)
         CFG_ZERO: c = '0;
         CFG_TOP:  c = '1;
         CFG_ONES: c = {7{16'd1}};
         CFG_DEFAULT: begin
            c.stop_delay_ms      = 16'd3000;
            c.arming_ms          = 16'd1000;
            c.keepalive_ms       = 16'd500;
            c.dual_window_ms     = 16'd150;
            c.dual_hold_ms       = 16'd600;
            c.menu_idle_limit_ms = 16'd1500;
            c.tap_window_ms      = 16'd1500;
         end
         CFG_WIDE: begin
            c.stop_delay_ms      = 16'($urandom_range(0, 65535));
            c.arming_ms          = 16'($urandom_range(0, 65535));
            c.keepalive_ms       = 16'($urandom_range(0, 65535));
            c.dual_window_ms     = 16'($urandom_range(0, 65535));
            c.dual_hold_ms       = 16'($urandom_range(0, 65535));
            c.menu_idle_limit_ms = 16'($urandom_range(0, 65535));
            c.tap_window_ms      = 16'($urandom_range(0, 65535));
         end
         default: begin
            c.stop_delay_ms      = 16'($urandom_range(0, 800));
            c.arming_ms          = 16'($urandom_range(1, 400));
            c.keepalive_ms       = 16'($urandom_range(1, 400));
            c.dual_window_ms     = 16'($urandom_range(1, 400));
            c.dual_hold_ms       = 16'($urandom_range(1, 400));
            c.menu_idle_limit_ms = 16'($urandom_range(1, 400));
            c.tap_window_ms      = 16'($urandom_range(1, 400));
         end
      endcase
      return c;
   endfunction

   task automatic send_pass(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'(r);
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      passes_sent++;
   endtask

   // The pending count is registered in the checker, so it is let update before it is trusted.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      logic [CSR_IDX_BITS-1:0] idx [8];
      cfg_word_type            val [8];
      idx = '{REG_STOP_DELAY, REG_ARMING, REG_KEEPALIVE, REG_DUAL_WINDOW,
              REG_DUAL_HOLD, REG_MENU_TIMEOUT, REG_TAP_WINDOW, UNUSED_REG};
      val = '{c.stop_delay_ms, c.arming_ms, c.keepalive_ms, c.dual_window_ms,
              c.dual_hold_ms, c.menu_idle_limit_ms, c.tap_window_ms,
              cfg_word_type'($urandom)};
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         @(posedge clock);
         while (!csr_ready) begin
            @(posedge clock);
         end
      end
      csr_valid <= 1'b0;
   endtask

   // Runs with the reset settings: a double tap in one pass, the menu and its timeout,
   // a full ride with start, keepalive and stop, a delay toggle and a link stop.
   task automatic directed_passes();
      send_pass(build_pass(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'd10));
      send_pass(build_pass(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'd10));
      send_pass(build_pass(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255));
      repeat (7) send_pass(build_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255));
      send_pass(build_pass(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'd100));
      send_pass(build_pass(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd200));
      repeat (4) send_pass(build_pass(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255));
      repeat (2) send_pass(build_pass(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd255));
      send_pass(build_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
      send_pass(build_pass(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'd100));
      send_pass(build_pass(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'd255));
      repeat (3) send_pass(build_pass(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd255));
      send_pass(build_pass(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'd0));
   endtask

   task automatic ride();
      logic u;
      logic dn;
      logic ev;
      int   n;
      u  = coin();
      dn = !u;
      n  = $urandom_range(2);
      repeat (n) send_pass(build_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, pick_dt()));
      ev = $urandom_range(3) != 0;
      send_pass(build_pass(u, dn, u & ev, dn & ev, 1'b0, pick_dt()));
      n = $urandom_range(1, 24);
      repeat (n) begin
         if ($urandom_range(7) == 0) begin
            u  = coin();
            dn = coin();
         end
         send_pass(build_pass(u, dn, 1'b0, 1'b0, rare_stop(), pick_dt()));
      end
      n = $urandom_range(1, 30);
      repeat (n) begin
         send_pass(build_pass(1'b0, 1'b0, $urandom_range(15) == 0, 1'b0, rare_stop(),
                              pick_dt()));
      end
   endtask

   task automatic dual_hold();
      logic u;
      logic both_on;
      int   n;
      u = coin();
      send_pass(build_pass(u, !u, u, !u, 1'b0, pick_dt()));
      send_pass(build_pass(1'b1, 1'b1, !u, u, 1'b0, pick_dt()));
      n = $urandom_range(1, 12);
      repeat (n) begin
         both_on = $urandom_range(9) != 0;
         send_pass(build_pass(1'b1, both_on, 1'b0, 1'b0, rare_stop(), pick_dt()));
      end
      n = $urandom_range(1, 4);
      repeat (n) send_pass(build_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, pick_dt()));
   endtask

   task automatic triple_tap();
      int         n;
      int         k;
      logic [7:0] dt;
      n = $urandom_range(2, 4);
      repeat (n) begin
         k  = $urandom_range(2);
         dt = ($urandom_range(3) == 0) ? pick_dt() : 8'($urandom_range(0, 120));
         send_pass(build_pass(coin(), coin(), k != 1, k != 0, 1'b0, dt));
      end
      n = $urandom_range(1, 12);
      repeat (n) begin
         send_pass(build_pass($urandom_range(3) == 0, $urandom_range(3) == 0,
                              $urandom_range(7) == 0, $urandom_range(7) == 0,
                              rare_stop(), pick_dt()));
      end
      n = $urandom_range(8);
      repeat (n) send_pass(build_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, pick_dt()));
   endtask

   task automatic noise();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         send_pass(build_pass(coin(), coin(),
                              $urandom_range(2) == 0, $urandom_range(2) == 0,
                              $urandom_range(7) == 0, 8'($urandom_range(255))));
      end
   endtask

   initial begin
      cfg_plan_type plan;
      int           budget;
      int           pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 33; stall_pct = 33; end
         endcase
         case (ph)
            0:       plan = CFG_RESET;
            2:       plan = CFG_ZERO;
            3:       plan = CFG_TOP;
            5:       plan = CFG_DEFAULT;
            6:       plan = CFG_WIDE;
            7:       plan = CFG_ONES;
            default: plan = CFG_SMALL;
         endcase
         if (plan != CFG_RESET) begin
            quiesce();
            program_regs(make_cfg(plan));
         end else begin
            directed_passes();
         end
         budget = passes_sent + PASSES_PER_PHASE;
         while (passes_sent < budget) begin
            if ($urandom_range(49) == 0) begin
               quiesce();
            end
            pick = $urandom_range(9);
            if (pick < 4) begin
               ride();
            end else if (pick < 6) begin
               dual_hold();
            end else if (pick < 8) begin
               triple_tap();
            end else begin
               noise();
            end
         end
      end
      quiesce();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_dead_man_switch_controller: PASS");
      end else begin
         $display("tb_dead_man_switch_controller: FAIL");
      end
      $finish;
   end

endmodule
